// File: rtl/core/tus_pkg.sv
package tus_pkg;

   localparam int unsigned MaxDivisions = 8;
   localparam int unsigned NumAxes      = 3;
   localparam int unsigned NumLanes     = 2 * NumAxes;
   localparam int unsigned CoordWidth   = 32;
   localparam int unsigned DivWidth     = 4;
   localparam int unsigned FracWidth    = $clog2(MaxDivisions);
   localparam int unsigned StepWidth    = $clog2(MaxDivisions);
   localparam int unsigned CountWidth   = $clog2(CoordWidth);
   localparam int unsigned MatWidth     = 16;

   typedef logic [NumAxes-1:0][CoordWidth-1:0] vertex_type;

   // Grid point per axis: value = whole + frac / n, with 0 <= frac < n.
   typedef struct packed {
      logic [CoordWidth-1:0] whole;
      logic [FracWidth-1:0]  frac;
   } grid_type;

   // One lane of the shared restoring divider.
   typedef struct packed {
      logic                  neg;
      logic [CoordWidth-1:0] bits;
      logic [FracWidth-1:0]  rem;
   } lane_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic init_a;
      logic init_b;
      logic step_col;
      logic step_row;
      logic upper;
   } cmd_type;

   function automatic grid_type grid_add(grid_type p, grid_type d, logic [DivWidth-1:0] n);
      logic [FracWidth:0] fsum;
      grid_type           res;
      fsum = {1'b0, p.frac} + {1'b0, d.frac};
      if (fsum >= n) begin
         res.frac  = FracWidth'(fsum - n);
         res.whole = p.whole + d.whole + CoordWidth'(1);
      end else begin
         res.frac  = fsum[FracWidth-1:0];
         res.whole = p.whole + d.whole;
      end
      return res;
   endfunction

   function automatic lane_type lane_init(logic signed [CoordWidth:0] diff);
      lane_type res;
      res.neg  = diff[CoordWidth];
      res.bits = diff[CoordWidth] ? ~diff[CoordWidth-1:0] : diff[CoordWidth-1:0];
      res.rem  = '0;
      return res;
   endfunction

   function automatic lane_type lane_step(lane_type l, logic [DivWidth-1:0] n);
      logic [FracWidth:0] trial;
      lane_type           res;
      trial   = {l.rem, l.bits[CoordWidth-1]};
      res.neg = l.neg;
      if (trial >= n) begin
         res.rem  = FracWidth'(trial - n);
         res.bits = {l.bits[CoordWidth-2:0], 1'b1};
      end else begin
         res.rem  = trial[FracWidth-1:0];
         res.bits = {l.bits[CoordWidth-2:0], 1'b0};
      end
      return res;
   endfunction

   // floor(e / n) of a negative e is ~floor(~e / n), with remainder n-1-rem.
   function automatic grid_type lane_result(lane_type l, logic [DivWidth-1:0] n);
      grid_type res;
      if (l.neg) begin
         res.whole = ~l.bits;
         res.frac  = FracWidth'(n - DivWidth'(1) - {1'b0, l.rem});
      end else begin
         res.whole = l.bits;
         res.frac  = l.rem;
      end
      return res;
   endfunction

endpackage

// File: rtl/core/tus_ctrl.sv
module tus_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tus_pkg::DivWidth-1:0]  n,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_last,
   output tus_pkg::cmd_type              cmd
);

   typedef enum logic [2:0] {
      IDLE,
      DIVIDE,
      INIT_A,
      INIT_B,
      EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [tus_pkg::CountWidth-1:0]   cnt_ff, cnt_in;
   logic [tus_pkg::StepWidth-1:0]    s_ff, s_in;
   logic [tus_pkg::StepWidth-1:0]    t_ff, t_in;
   logic                             upper_ff, upper_in;
   logic                             stall_ff, stall_in;
   logic                             valid_ff, valid_in;

   logic                             accept;
   logic                             take;
   logic [tus_pkg::DivWidth-1:0]     lim;
   logic                             at_end;
   logic                             row_last;

   assign accept   = req_valid && !stall_ff;
   assign take     = valid_ff && !rsp_stall;
   assign lim      = n - tus_pkg::DivWidth'(1) - {1'b0, t_ff};
   assign at_end   = ({1'b0, s_ff} == lim);
   assign row_last = ({1'b0, t_ff} == n - tus_pkg::DivWidth'(1));

   assign req_stall = stall_ff;
   assign rsp_valid = valid_ff;
   assign rsp_last  = !upper_ff && at_end && row_last;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == IDLE) && accept;
      cmd.div_step = (state_ff == DIVIDE);
      cmd.init_a   = (state_ff == INIT_A);
      cmd.init_b   = (state_ff == INIT_B);
      cmd.step_col = (state_ff == EMIT) && take && upper_ff;
      cmd.step_row = (state_ff == EMIT) && take && !upper_ff && at_end && !row_last;
      cmd.upper    = upper_ff;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      s_in     = s_ff;
      t_in     = t_ff;
      upper_in = upper_ff;
      stall_in = stall_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         IDLE: begin
            stall_in = 1'b0;
            if (accept) begin
               state_in = DIVIDE;
               cnt_in   = '0;
               stall_in = 1'b1;
            end
         end
         DIVIDE: begin
            cnt_in = cnt_ff + tus_pkg::CountWidth'(1);
            if (cnt_ff == tus_pkg::CountWidth'(tus_pkg::CoordWidth - 1)) begin
               state_in = INIT_A;
            end
         end
         INIT_A: begin
            state_in = INIT_B;
         end
         INIT_B: begin
            state_in = EMIT;
            valid_in = 1'b1;
            s_in     = '0;
            t_in     = '0;
            upper_in = 1'b0;
         end
         EMIT: begin
            if (take) begin
               if (upper_ff) begin
                  upper_in = 1'b0;
                  s_in     = s_ff + tus_pkg::StepWidth'(1);
               end else if (!at_end) begin
                  upper_in = 1'b1;
               end else if (!row_last) begin
                  t_in = t_ff + tus_pkg::StepWidth'(1);
                  s_in = '0;
               end else begin
                  state_in = IDLE;
                  valid_in = 1'b0;
                  stall_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         cnt_ff   <= '0;
         s_ff     <= '0;
         t_ff     <= '0;
         upper_ff <= 1'b0;
         stall_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         s_ff     <= s_in;
         t_ff     <= t_in;
         upper_ff <= upper_in;
         stall_ff <= stall_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/core/tus_datapath.sv
module tus_datapath (
   input  logic                          clock,
   input  logic [tus_pkg::DivWidth-1:0]  n,
   input  tus_pkg::cmd_type              cmd,
   input  tus_pkg::vertex_type           a,
   input  tus_pkg::vertex_type           b,
   input  tus_pkg::vertex_type           c,
   input  logic [tus_pkg::MatWidth-1:0]  material,
   output tus_pkg::vertex_type           p,
   output tus_pkg::vertex_type           q,
   output tus_pkg::vertex_type           r,
   output logic [tus_pkg::MatWidth-1:0]  material_out
);

   tus_pkg::vertex_type                        base_ff, base_in;
   logic [tus_pkg::MatWidth-1:0]               mat_ff, mat_in;
   tus_pkg::lane_type [tus_pkg::NumLanes-1:0]  lane_ff, lane_in;

   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   a_ff, a_in;
   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   a1_ff, a1_in;
   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   b_ff, b_in;
   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   b1_ff, b1_in;
   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   rb_ff, rb_in;
   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   rb1_ff, rb1_in;

   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   origin;
   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   d12;
   tus_pkg::grid_type [tus_pkg::NumAxes-1:0]   d13;
   logic signed [tus_pkg::CoordWidth:0]        diff12 [tus_pkg::NumAxes];
   logic signed [tus_pkg::CoordWidth:0]        diff13 [tus_pkg::NumAxes];

   always_comb begin
      for (int k = 0; k < tus_pkg::NumAxes; k++) begin
         diff12[k]       = $signed({b[k][tus_pkg::CoordWidth-1], b[k]})
                         - $signed({a[k][tus_pkg::CoordWidth-1], a[k]});
         diff13[k]       = $signed({c[k][tus_pkg::CoordWidth-1], c[k]})
                         - $signed({a[k][tus_pkg::CoordWidth-1], a[k]});
         origin[k].whole = base_ff[k];
         origin[k].frac  = '0;
         d12[k]          = tus_pkg::lane_result(lane_ff[k], n);
         d13[k]          = tus_pkg::lane_result(lane_ff[tus_pkg::NumAxes + k], n);
      end
   end

   always_comb begin
      base_in = base_ff;
      mat_in  = mat_ff;
      lane_in = lane_ff;
      if (cmd.load) begin
         base_in = a;
         mat_in  = material;
         for (int k = 0; k < tus_pkg::NumAxes; k++) begin
            lane_in[k]                    = tus_pkg::lane_init(diff12[k]);
            lane_in[tus_pkg::NumAxes + k] = tus_pkg::lane_init(diff13[k]);
         end
      end else if (cmd.div_step) begin
         for (int l = 0; l < tus_pkg::NumLanes; l++) begin
            lane_in[l] = tus_pkg::lane_step(lane_ff[l], n);
         end
      end
   end

   always_comb begin
      a_in   = a_ff;
      a1_in  = a1_ff;
      b_in   = b_ff;
      b1_in  = b1_ff;
      rb_in  = rb_ff;
      rb1_in = rb1_ff;
      for (int k = 0; k < tus_pkg::NumAxes; k++) begin
         if (cmd.init_a) begin
            a_in[k]  = origin[k];
            a1_in[k] = tus_pkg::grid_add(origin[k], d12[k], n);
            b_in[k]  = tus_pkg::grid_add(origin[k], d13[k], n);
            rb_in[k] = tus_pkg::grid_add(origin[k], d13[k], n);
         end else if (cmd.init_b) begin
            b1_in[k]  = tus_pkg::grid_add(b_ff[k], d12[k], n);
            rb1_in[k] = tus_pkg::grid_add(b_ff[k], d12[k], n);
         end else if (cmd.step_col) begin
            a_in[k]  = a1_ff[k];
            a1_in[k] = tus_pkg::grid_add(a1_ff[k], d12[k], n);
            b_in[k]  = b1_ff[k];
            b1_in[k] = tus_pkg::grid_add(b1_ff[k], d12[k], n);
         end else if (cmd.step_row) begin
            a_in[k]   = rb_ff[k];
            a1_in[k]  = rb1_ff[k];
            b_in[k]   = tus_pkg::grid_add(rb_ff[k], d13[k], n);
            b1_in[k]  = tus_pkg::grid_add(rb1_ff[k], d13[k], n);
            rb_in[k]  = tus_pkg::grid_add(rb_ff[k], d13[k], n);
            rb1_in[k] = tus_pkg::grid_add(rb1_ff[k], d13[k], n);
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      mat_ff  <= mat_in;
      lane_ff <= lane_in;
      a_ff    <= a_in;
      a1_ff   <= a1_in;
      b_ff    <= b_in;
      b1_ff   <= b1_in;
      rb_ff   <= rb_in;
      rb1_ff  <= rb1_in;
   end

   always_comb begin
      for (int k = 0; k < tus_pkg::NumAxes; k++) begin
         p[k] = cmd.upper ? b_ff[k].whole : a_ff[k].whole;
         q[k] = a1_ff[k].whole;
         r[k] = cmd.upper ? b1_ff[k].whole : b_ff[k].whole;
      end
   end

   assign material_out = mat_ff;

endmodule

// File: rtl/core/triangle_uniform_subdivider.sv
// Splits each requested triangle into n*n sub-triangles, n being the division
// count in the csr register (0 acts as 1, above 8 acts as 8). After a request
// is taken, a restoring divider shared by six lanes (both edges, three axes)
// steps bit by bit through each coordinate difference to split every edge step
// into a whole part and a remainder in n-ths, the INIT_A and INIT_B states set
// up the grid walkers, and then one sub-triangle goes out per cycle while
// rsp_stall is low. The next request is taken only after the last sub-triangle
// (rsp_last high) of the current one is delivered. Write csr only while no
// request is in flight.
module triangle_uniform_subdivider (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tus_pkg::DivWidth-1:0]  csr_divisions,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [31:0]                   req_a_x,
   input  logic [31:0]                   req_a_y,
   input  logic [31:0]                   req_a_z,
   input  logic [31:0]                   req_b_x,
   input  logic [31:0]                   req_b_y,
   input  logic [31:0]                   req_b_z,
   input  logic [31:0]                   req_c_x,
   input  logic [31:0]                   req_c_y,
   input  logic [31:0]                   req_c_z,
   input  logic [15:0]                   req_material,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [31:0]                   rsp_p_x,
   output logic [31:0]                   rsp_p_y,
   output logic [31:0]                   rsp_p_z,
   output logic [31:0]                   rsp_q_x,
   output logic [31:0]                   rsp_q_y,
   output logic [31:0]                   rsp_q_z,
   output logic [31:0]                   rsp_r_x,
   output logic [31:0]                   rsp_r_y,
   output logic [31:0]                   rsp_r_z,
   output logic [15:0]                   rsp_material_out,
   output logic                          rsp_last
);

   logic [tus_pkg::DivWidth-1:0]  divisions_ff, divisions_in;
   logic [tus_pkg::DivWidth-1:0]  n_eff;
   tus_pkg::cmd_type              cmd;
   tus_pkg::vertex_type           a_vec, b_vec, c_vec;
   tus_pkg::vertex_type           p_vec, q_vec, r_vec;

   assign csr_ready    = 1'b1;
   assign divisions_in = csr_valid ? csr_divisions : divisions_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisions_ff <= tus_pkg::DivWidth'(1);
      end else begin
         divisions_ff <= divisions_in;
      end
   end

   always_comb begin
      if (divisions_ff == '0) begin
         n_eff = tus_pkg::DivWidth'(1);
      end else if (divisions_ff > tus_pkg::DivWidth'(tus_pkg::MaxDivisions)) begin
         n_eff = tus_pkg::DivWidth'(tus_pkg::MaxDivisions);
      end else begin
         n_eff = divisions_ff;
      end
   end

   assign a_vec = {req_a_z, req_a_y, req_a_x};
   assign b_vec = {req_b_z, req_b_y, req_b_x};
   assign c_vec = {req_c_z, req_c_y, req_c_x};

   tus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .n         (n_eff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_last  (rsp_last),
      .cmd       (cmd)
   );

   tus_datapath u_datapath (
      .clock        (clock),
      .n            (n_eff),
      .cmd          (cmd),
      .a            (a_vec),
      .b            (b_vec),
      .c            (c_vec),
      .material     (req_material),
      .p            (p_vec),
      .q            (q_vec),
      .r            (r_vec),
      .material_out (rsp_material_out)
   );

   assign rsp_p_x = p_vec[0];
   assign rsp_p_y = p_vec[1];
   assign rsp_p_z = p_vec[2];
   assign rsp_q_x = q_vec[0];
   assign rsp_q_y = q_vec[1];
   assign rsp_q_z = q_vec[2];
   assign rsp_r_x = r_vec[0];
   assign rsp_r_y = r_vec[1];
   assign rsp_r_z = r_vec[2];

endmodule

// File: rtl/core/tus_checker.sv
module tus_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_p_x,
   input logic [31:0] rsp_q_y,
   input logic [31:0] rsp_r_z,
   input logic [15:0] rsp_material_out,
   input logic        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_p_x) && $stable(rsp_q_y)
         && $stable(rsp_r_z) && $stable(rsp_material_out) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("request taken while previous one still in flight");

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while sub-triangles pending");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !rsp_valid)
      else $error("response continued past last sub-triangle");

endmodule

bind triangle_uniform_subdivider tus_checker u_tus_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_p_x          (rsp_p_x),
   .rsp_q_y          (rsp_q_y),
   .rsp_r_z          (rsp_r_z),
   .rsp_material_out (rsp_material_out),
   .rsp_last         (rsp_last)
);
